FILE: rtl/cef_pkg.sv
package cef_pkg;

  localparam int DEPTH = 48;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int FILL_W = 6;

  localparam logic [1:0] MODE_POST = 2'd0;
  localparam logic [1:0] MODE_FOLD = 2'd1;
  localparam logic [1:0] MODE_POP = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [15:0] event_type;
    logic [31:0] payload;
    logic [31:0] target_tag;
    logic [31:0] sender_tag;
  } rec_t;

  typedef struct packed {
    logic pop;
    logic rot;
    logic post;
  } cell_ctl_t;

endpackage

FILE: rtl/cef_cell.sv
module cef_cell import cef_pkg::*; (
  input  logic             clk,
  input  logic [IDX_W-1:0] idx,
  input  cell_ctl_t        ctl,
  input  logic [CNT_W-1:0] count,
  input  rec_t             in_rec,
  input  rec_t             nbr_rec,
  input  rec_t             head_rec,
  output rec_t             rec
);

  rec_t             rec_r;
  rec_t             rec_nxt;
  logic [CNT_W-1:0] idx_ext;
  logic [CNT_W-1:0] idx_p1;

  assign idx_ext = CNT_W'(idx);
  assign idx_p1  = CNT_W'(idx_ext + 1'b1);
  assign rec     = rec_r;

  always_comb begin
    rec_nxt = rec_r;
    priority if (ctl.pop) begin
      rec_nxt = nbr_rec;
    end else if (ctl.rot && idx_p1 < count) begin
      rec_nxt = nbr_rec;
    end else if (ctl.rot && idx_p1 == count) begin
      rec_nxt = head_rec;
    end else if (ctl.post && idx_ext == count) begin
      rec_nxt = in_rec;
    end else begin
      rec_nxt = rec_r;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

endmodule

FILE: rtl/coalescing_event_fifo.sv
// Channel   Handshake          Payload
// input     start / busy       in_mode, in_event_type, in_payload, in_target_tag, in_sender_tag
// result    out_strobe         out_status, out_was_folded, out_type, out_payload, out_target,
//                              out_sender, out_fill_level
//
// Post, pop, no-op and empty-queue fold words give a result that strobes in the next cycle.
// A fold on a non-empty queue rotates the cell chain once per pending record, so it keeps
// busy high while it scans the pending records, and its result strobes as busy falls.
// The synchronous active-low reset empties the queue; record cells hold no reset value.
// The result strobe lasts one cycle and the receiver cannot stall it.
module coalescing_event_fifo import cef_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_mode,
  input  logic [15:0]       in_event_type,
  input  logic [31:0]       in_payload,
  input  logic [31:0]       in_target_tag,
  input  logic [31:0]       in_sender_tag,
  output logic              out_strobe,
  output logic [1:0]        out_status,
  output logic              out_was_folded,
  output logic [15:0]       out_type,
  output logic [31:0]       out_payload,
  output logic [31:0]       out_target,
  output logic [31:0]       out_sender,
  output logic [FILL_W-1:0] out_fill_level
);

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  state_t           state_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] scan_left_r;
  logic             hit_r;
  rec_t             req_r;
  logic             strobe_r;
  logic [1:0]       status_r;
  logic             folded_r;
  rec_t             out_rec_r;
  logic [CNT_W-1:0] fill_r;

  rec_t             cell_rec [DEPTH];
  rec_t             port_rec;
  rec_t             in_rec;
  rec_t             head_rec;
  cell_ctl_t        ctl;
  logic             accept;
  logic             not_full;
  logic             match;
  logic             hit_any;
  logic             last_rot;

  assign accept   = start && state_r == S_IDLE;
  assign busy     = state_r != S_IDLE;
  assign not_full = count_r < CNT_W'(DEPTH);
  assign match    = state_r == S_SCAN && !hit_r && cell_rec[0].event_type == req_r.event_type;
  assign hit_any  = hit_r || match;
  assign last_rot = scan_left_r == CNT_W'(1);

  assign port_rec = '{event_type: in_event_type, payload: in_payload,
                      target_tag: in_target_tag, sender_tag: in_sender_tag};
  assign in_rec   = (state_r == S_SCAN) ? req_r : port_rec;

  always_comb begin
    head_rec = cell_rec[0];
    if (match) begin
      head_rec.payload = req_r.payload;
    end
  end

  always_comb begin
    ctl.pop  = accept && in_mode == MODE_POP && count_r != '0;
    ctl.rot  = state_r == S_SCAN;
    ctl.post = (accept && in_mode == MODE_POST && not_full)
            || (accept && in_mode == MODE_FOLD && count_r == '0)
            || (state_r == S_SCAN && last_rot && !hit_any && not_full);
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    rec_t nbr;
    if (i < DEPTH - 1) begin : g_mid
      assign nbr = cell_rec[i+1];
    end else begin : g_end
      assign nbr = '0;
    end
    cef_cell u_cell (
      .clk      (clk),
      .idx      (IDX_W'(i)),
      .ctl      (ctl),
      .count    (count_r),
      .in_rec   (in_rec),
      .nbr_rec  (nbr),
      .head_rec (head_rec),
      .rec      (cell_rec[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      scan_left_r <= '0;
      hit_r       <= 1'b0;
      strobe_r    <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            status_r  <= ST_OK;
            folded_r  <= 1'b0;
            out_rec_r <= '0;
            fill_r    <= count_r;
            strobe_r  <= 1'b1;
            unique case (in_mode)
              MODE_POST: begin
                if (not_full) begin
                  count_r <= CNT_W'(count_r + 1'b1);
                  fill_r  <= CNT_W'(count_r + 1'b1);
                end else begin
                  status_r <= ST_FULL;
                end
              end
              MODE_FOLD: begin
                if (count_r == '0) begin
                  count_r <= CNT_W'(1);
                  fill_r  <= CNT_W'(1);
                end else begin
                  strobe_r    <= 1'b0;
                  req_r       <= port_rec;
                  scan_left_r <= count_r;
                  hit_r       <= 1'b0;
                  state_r     <= S_SCAN;
                end
              end
              MODE_POP: begin
                if (count_r == '0) begin
                  status_r <= ST_EMPTY;
                end else begin
                  out_rec_r <= cell_rec[0];
                  count_r   <= CNT_W'(count_r - 1'b1);
                  fill_r    <= CNT_W'(count_r - 1'b1);
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          hit_r       <= hit_any;
          scan_left_r <= CNT_W'(scan_left_r - 1'b1);
          if (last_rot) begin
            state_r   <= S_IDLE;
            strobe_r  <= 1'b1;
            out_rec_r <= '0;
            folded_r  <= hit_any;
            status_r  <= ST_OK;
            fill_r    <= count_r;
            if (!hit_any) begin
              if (not_full) begin
                count_r <= CNT_W'(count_r + 1'b1);
                fill_r  <= CNT_W'(count_r + 1'b1);
              end else begin
                status_r <= ST_FULL;
              end
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_strobe     = strobe_r;
  assign out_status     = status_r;
  assign out_was_folded = folded_r;
  assign out_type       = out_rec_r.event_type;
  assign out_payload    = out_rec_r.payload;
  assign out_target     = out_rec_r.target_tag;
  assign out_sender     = out_rec_r.sender_tag;
  assign out_fill_level = FILL_W'(fill_r);

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("pending count exceeds the queue depth");

  a_quick_result : assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_mode != MODE_FOLD |=> out_strobe)
    else $error("post, pop or no-op word gave no result in the next cycle");

  a_empty_fill : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status == ST_EMPTY |-> out_fill_level == '0)
    else $error("empty pop reported a nonzero fill level");

  a_fold_ok : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_was_folded |-> out_status == ST_OK && out_type == '0)
    else $error("folded result carries a bad status or record");

  a_scan_len : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> scan_left_r != '0 && scan_left_r <= count_r)
    else $error("fold scan counter out of range");

endmodule

FILE: tb/sv/coalescing_event_fifo_tb.sv
module coalescing_event_fifo_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cef_pkg::*;

  localparam logic [1:0] MODE_NOP = 2'd3;
  localparam int QUIET_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] etype;
    logic [31:0] pay;
    logic [31:0] tgt;
    logic [31:0] snd;
  } event_word_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              folded;
    logic [15:0]       rtype;
    logic [31:0]       rpay;
    logic [31:0]       rtgt;
    logic [31:0]       rsnd;
    logic [FILL_W-1:0] fill;
  } fifo_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        in_mode = MODE_NOP;
  logic [15:0]       in_event_type = '0;
  logic [31:0]       in_payload = '0;
  logic [31:0]       in_target_tag = '0;
  logic [31:0]       in_sender_tag = '0;
  logic              out_strobe;
  logic [1:0]        out_status;
  logic              out_was_folded;
  logic [15:0]       out_type;
  logic [31:0]       out_payload;
  logic [31:0]       out_target;
  logic [31:0]       out_sender;
  logic [FILL_W-1:0] out_fill_level;

  event_word_t  stim_q[$];
  rec_t         queued_events[$];
  fifo_result_t due_results[$];

  int total_words = 0;
  int words_issued = 0;
  int quiet_cycles = 0;
  int n_mismatch = 0;
  int n_post_ok = 0;
  int n_fold_hit = 0;
  int n_dropped = 0;
  int n_pop_ok = 0;
  int n_pop_empty = 0;
  int n_nop = 0;
  int max_fill = 0;

  coalescing_event_fifo uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_mode(in_mode),
    .in_event_type(in_event_type),
    .in_payload(in_payload),
    .in_target_tag(in_target_tag),
    .in_sender_tag(in_sender_tag),
    .out_strobe(out_strobe),
    .out_status(out_status),
    .out_was_folded(out_was_folded),
    .out_type(out_type),
    .out_payload(out_payload),
    .out_target(out_target),
    .out_sender(out_sender),
    .out_fill_level(out_fill_level)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void apply_event_op(event_word_t w);
    fifo_result_t r;
    rec_t rec;
    int hit;
    r = '0;
    hit = -1;
    rec.event_type = w.etype;
    rec.payload = w.pay;
    rec.target_tag = w.tgt;
    rec.sender_tag = w.snd;
    case (w.mode)
      MODE_POST: begin
        if (queued_events.size() < DEPTH) begin
          queued_events.push_back(rec);
          n_post_ok++;
        end else begin
          r.status = ST_FULL;
          n_dropped++;
        end
      end
      MODE_FOLD: begin
        foreach (queued_events[i])
          if (hit < 0 && queued_events[i].event_type == w.etype) hit = i;
        if (hit >= 0) begin
          rec = queued_events[hit];
          rec.payload = w.pay;
          queued_events[hit] = rec;
          r.folded = 1'b1;
          n_fold_hit++;
        end else if (queued_events.size() < DEPTH) begin
          queued_events.push_back(rec);
          n_post_ok++;
        end else begin
          r.status = ST_FULL;
          n_dropped++;
        end
      end
      MODE_POP: begin
        if (queued_events.size() == 0) begin
          r.status = ST_EMPTY;
          n_pop_empty++;
        end else begin
          rec = queued_events.pop_front();
          r.rtype = rec.event_type;
          r.rpay = rec.payload;
          r.rtgt = rec.target_tag;
          r.rsnd = rec.sender_tag;
          n_pop_ok++;
        end
      end
      default: n_nop++;
    endcase
    r.fill = FILL_W'(queued_events.size());
    if (queued_events.size() > max_fill) max_fill = queued_events.size();
    due_results.push_back(r);
  endfunction

  function automatic int sender_idle_pct();
    if (words_issued < total_words / 3) return 34;
    if (words_issued < (2 * total_words) / 3) return 59;
    return 0;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      n_mismatch++;
    end
  endfunction

  always @(posedge clk) begin
    logic taken;
    event_word_t nxt;
    taken = start && !busy;
    if (taken)
      apply_event_op({in_mode, in_event_type, in_payload, in_target_tag, in_sender_tag});
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !taken) begin
      start <= 1'b1;
    end else if (stim_q.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
      nxt = stim_q.pop_front();
      words_issued++;
      in_mode <= nxt.mode;
      in_event_type <= nxt.etype;
      in_payload <= nxt.pay;
      in_target_tag <= nxt.tgt;
      in_sender_tag <= nxt.snd;
      start <= 1'b1;
    end else begin
      start <= 1'b0;
    end
  end

  always @(posedge clk) begin
    fifo_result_t want;
    if (rst_n && out_strobe) begin
      if (due_results.size() == 0) begin
        $display("%0t ns: result word with none expected, status %0d fill %0d", $time,
                 out_status, out_fill_level);
        n_mismatch++;
      end else begin
        want = due_results.pop_front();
        check_field("status", 32'(want.status), 32'(out_status));
        check_field("was_folded", 32'(want.folded), 32'(out_was_folded));
        check_field("out_type", 32'(want.rtype), 32'(out_type));
        check_field("out_payload", want.rpay, out_payload);
        check_field("out_target", want.rtgt, out_target);
        check_field("out_sender", want.rsnd, out_sender);
        check_field("fill_level", 32'(want.fill), 32'(out_fill_level));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t ns: no word accepted for %0d cycles", $time, quiet_cycles);
      $display("** coalescing_event_fifo: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void add_word(logic [1:0] m, logic [15:0] t, logic [31:0] p,
                                   logic [31:0] tg, logic [31:0] s);
    event_word_t w;
    w.mode = m;
    w.etype = t;
    w.pay = p;
    w.tgt = tg;
    w.snd = s;
    stim_q.push_back(w);
  endfunction

  function automatic logic [15:0] pick_type();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) return 16'($urandom_range(11));
    if (roll < 70) return ($urandom_range(1) != 0) ? 16'hffff : 16'h0000;
    return 16'($urandom);
  endfunction

  function automatic logic [31:0] pick_tag();
    return ($urandom_range(9) == 0) ? 32'h0 : $urandom;
  endfunction

  function automatic void add_random_word(int pct_post, int pct_fold, int pct_pop);
    int roll;
    logic [1:0] m;
    roll = $urandom_range(99);
    if (roll < pct_post) m = MODE_POST;
    else if (roll < pct_post + pct_fold) m = MODE_FOLD;
    else if (roll < pct_post + pct_fold + pct_pop) m = MODE_POP;
    else m = MODE_NOP;
    add_word(m, pick_type(), $urandom, pick_tag(), $urandom);
  endfunction

  initial begin
    int seg_len;
    int kind;

    add_word(MODE_POP, 16'h1234, 32'h1, 32'h2, 32'h3);
    add_word(MODE_NOP, 16'hffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    add_word(MODE_FOLD, 16'h0000, 32'h0, 32'h0, 32'h0);
    add_word(MODE_POST, 16'hffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    add_word(MODE_POST, 16'h0005, 32'h55aa55aa, 32'h0, 32'h00000005);
    add_word(MODE_FOLD, 16'h0005, 32'haa55aa55, 32'h11111111, 32'h22222222);
    add_word(MODE_FOLD, 16'hffff, 32'h00000000, 32'h0, 32'h0);
    add_word(MODE_FOLD, 16'h0000, 32'hdeadbeef, 32'h33333333, 32'h44444444);
    add_word(MODE_NOP, 16'h0000, 32'h0, 32'h0, 32'h0);
    add_word(MODE_POP, 16'h0, 32'h0, 32'h0, 32'h0);
    add_word(MODE_POP, 16'h0, 32'h0, 32'h0, 32'h0);
    add_word(MODE_POP, 16'h0, 32'h0, 32'h0, 32'h0);
    add_word(MODE_POP, 16'h0, 32'h0, 32'h0, 32'h0);
    add_word(MODE_POST, 16'h0007, 32'h70000001, 32'h7, 32'h1);
    add_word(MODE_POST, 16'h0008, 32'h80000002, 32'h8, 32'h2);
    add_word(MODE_POST, 16'h0007, 32'h70000003, 32'h7, 32'h3);
    add_word(MODE_FOLD, 16'h0007, 32'hcafef00d, 32'h9, 32'h9);
    add_word(MODE_FOLD, 16'h0009, 32'h90000004, 32'h9, 32'h4);
    add_word(MODE_POP, 16'h0, 32'h0, 32'h0, 32'h0);
    add_word(MODE_POP, 16'h0, 32'h0, 32'h0, 32'h0);
    add_word(MODE_POP, 16'h0, 32'h0, 32'h0, 32'h0);
    add_word(MODE_POP, 16'h0, 32'h0, 32'h0, 32'h0);
    add_word(MODE_POP, 16'h0, 32'h0, 32'h0, 32'h0);

    repeat (DEPTH + 2)
      add_word(MODE_POST, 16'($urandom_range(11)), $urandom, pick_tag(), $urandom);
    add_word(MODE_FOLD, 16'h8000, $urandom, $urandom, $urandom);
    add_word(MODE_FOLD, 16'($urandom_range(11)), $urandom, $urandom, $urandom);
    add_word(MODE_FOLD, 16'hffff, $urandom, $urandom, $urandom);
    add_word(MODE_POP, 16'h0, 32'h0, 32'h0, 32'h0);
    add_word(MODE_FOLD, 16'h8001, $urandom, $urandom, $urandom);
    add_word(MODE_POST, 16'h8002, $urandom, $urandom, $urandom);
    repeat (DEPTH + 2) add_random_word(5, 5, 90);

    while (stim_q.size() < 425) begin
      kind = $urandom_range(2);
      seg_len = (kind == 2) ? $urandom_range(20, 50) : $urandom_range(50, 60);
      repeat (seg_len) begin
        case (kind)
          0: add_random_word(80, 15, 5);
          1: add_random_word(5, 7, 88);
          default: add_random_word(30, 30, 30);
        endcase
      end
    end
    total_words = stim_q.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (stim_q.size() != 0 || start || due_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d words: %0d records queued, %0d folded in place, %0d dropped full,",
             total_words, n_post_ok, n_fold_hit, n_dropped);
    $display("%0d popped, %0d pops on empty, %0d no-ops, peak fill %0d of %0d.",
             n_pop_ok, n_pop_empty, n_nop, max_fill, DEPTH);
    if (n_mismatch == 0 && due_results.size() == 0) begin
      $display("** coalescing_event_fifo: PASSED **");
    end else begin
      $display("** coalescing_event_fifo: FAILED **");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/cef_pkg.sv
rtl/cef_cell.sv
rtl/coalescing_event_fifo.sv
tb/sv/coalescing_event_fifo_tb.sv
